// ----- hdl/abc_pkg.sv -----
// package with shared constants and types for the block cache
`default_nettype none
package abc_pkg;
    localparam int unsigned LINES_DEF = 64;
    localparam int unsigned WORDS_PER_LINE = 32;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned KEY_W = 40;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned CFG_W = 7;
    localparam int unsigned WIDX_W = 5;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_STREAM,
        ST_PUT_WRITE
    } state_t;
endpackage
`default_nettype wire

// ----- hdl/abc_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module abc_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/assoc_block_cache_lru_core.sv -----
// top level of the fully associative block cache with stamp replacement
//
// Items enter on start when busy is low. A get (opcode 0) scans the key and
// stamp memories one line per cycle over the lines in use, then on a hit
// streams the 32 words of the line, one per cycle, on result_valid with
// last on the final word; a miss gives one result with hit low. A put with
// word_index 0 also scans (match, first empty line, else smallest stamp),
// then writes key, stamp and word 0 and gives one result. A put with other
// word_index writes the word into the chosen line while idle, no result.
// The scan reads one line per cycle through the single read port
// of the key and stamp memories, so a get or a put with word_index 0 keeps
// busy high while the lines in use are scanned; a get miss or such a put
// shows its result as busy drops. A get hit shows its 32 words back to
// back, and busy drops while word 31 is shown. Counts saturate at 2^32-1.
// Reset clears valid bits (flip-flops), counters, stamp clock, and sets
// lines_in_use to 64. The receiver cannot stall: each result is shown for
// exactly one cycle and busy keeps new items out until the item is done.
`default_nettype none
module assoc_block_cache_lru_core
    import abc_pkg::*;
#(
    parameter int unsigned LINES = LINES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                opcode,
    input  wire logic [7:0]          dev_num,
    input  wire logic [15:0]         sector,
    input  wire logic [15:0]         block_num,
    input  wire logic [WIDX_W-1:0]   word_index,
    input  wire logic [WORD_W-1:0]   data_word,
    input  wire logic                cfg_we,
    input  wire logic [CFG_W-1:0]    cfg_wdata,
    output logic                     result_valid,
    output logic                     hit,
    output logic [WORD_W-1:0]        read_word,
    output logic                     last,
    output logic [CNT_W-1:0]         hit_count,
    output logic [CNT_W-1:0]         access_count
);
    localparam int unsigned LW = $clog2(LINES);
    localparam int unsigned DW = $clog2(LINES * WORDS_PER_LINE);
    localparam int unsigned NW = LW + 1;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     lines_cfg_reg;
    logic [LINES-1:0]     valid_reg, valid_next;
    logic [STAMP_W-1:0]   clock_reg, clock_next;
    logic [LW-1:0]        chosen_reg, chosen_next;
    logic [CNT_W-1:0]     hits_reg, hits_next, looks_reg, looks_next;
    op_t                  op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [WORD_W-1:0]    data_reg, data_next;
    logic [NW-1:0]        idx_reg, idx_next;     // line being read
    logic [NW-1:0]        cmp_reg, cmp_next;     // line whose data arrives
    logic                 found_reg, found_next;
    logic [LW-1:0]        match_reg, match_next;
    logic                 empty_reg, empty_next;
    logic [LW-1:0]        empty_idx_reg, empty_idx_next;
    logic [STAMP_W-1:0]   best_reg, best_next;
    logic [LW-1:0]        best_idx_reg, best_idx_next;
    logic [WIDX_W-1:0]    w_reg, w_next;
    logic                 rv_next, hit_next, last_next;
    logic                 out_word_reg, out_word_next;
    logic                 out_hit_reg, out_last_reg;
    logic                 out_valid_reg;

    // active line count, 0 acts as 1 and clipped to built size
    logic [NW-1:0] n_act;
    always_comb
    begin
        if (lines_cfg_reg == '0)
            n_act = NW'(1);
        else if (32'(lines_cfg_reg) > LINES)
            n_act = NW'(LINES);
        else
            n_act = NW'(lines_cfg_reg);
    end

    // tag memories
    logic             tag_we;
    logic [LW-1:0]    tag_waddr, tag_raddr;
    logic [KEY_W-1:0] key_rd;
    logic [STAMP_W-1:0] stamp_rd;
    logic             dat_we;
    logic [DW-1:0]    dat_waddr, dat_raddr;
    logic [WORD_W-1:0] dat_wdata, dat_rd;

    abc_ram #(.WIDTH(KEY_W), .DEPTH(LINES)) u_key_ram (
        .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(key_reg),
        .raddr(tag_raddr), .rdata(key_rd));
    abc_ram #(.WIDTH(STAMP_W), .DEPTH(LINES)) u_stamp_ram (
        .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(clock_next),
        .raddr(tag_raddr), .rdata(stamp_rd));
    abc_ram #(.WIDTH(WORD_W), .DEPTH(LINES * WORDS_PER_LINE)) u_data_ram (
        .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
        .raddr(dat_raddr), .rdata(dat_rd));

    logic [KEY_W-1:0] in_key;
    assign in_key = {dev_num, sector, block_num};
    assign busy = (state_reg != ST_IDLE);
    // line 0 is read while idle so the scan starts on it
    assign tag_raddr = (state_reg == ST_IDLE) ? '0 : idx_reg[LW-1:0];

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lines_cfg_reg <= CFG_W'(64);
            valid_reg     <= '0;
            clock_reg     <= '0;
            chosen_reg    <= '0;
            hits_reg      <= '0;
            looks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                lines_cfg_reg <= cfg_wdata;
            valid_reg     <= valid_next;
            clock_reg     <= clock_next;
            chosen_reg    <= chosen_next;
            hits_reg      <= hits_next;
            looks_reg     <= looks_next;
            out_valid_reg <= rv_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        data_reg      <= data_next;
        idx_reg       <= idx_next;
        cmp_reg       <= cmp_next;
        found_reg     <= found_next;
        match_reg     <= match_next;
        empty_reg     <= empty_next;
        empty_idx_reg <= empty_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        w_reg         <= w_next;
        out_hit_reg   <= hit_next;
        out_last_reg  <= last_next;
        out_word_reg  <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign hit          = out_hit_reg;
    assign last         = out_last_reg;
    assign read_word    = out_word_reg ? dat_rd : '0;
    assign hit_count    = hits_reg;
    assign access_count = looks_reg;

    // next state and control
    logic [LW-1:0] cl;
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        clock_next = clock_reg;
        chosen_next = chosen_reg;
        hits_next = hits_reg;
        looks_next = looks_reg;
        op_next = op_reg;
        key_next = key_reg;
        data_next = data_reg;
        idx_next = idx_reg;
        cmp_next = cmp_reg;
        found_next = found_reg;
        match_next = match_reg;
        empty_next = empty_reg;
        empty_idx_next = empty_idx_reg;
        best_next = best_reg;
        best_idx_next = best_idx_reg;
        w_next = w_reg;
        rv_next = 1'b0;
        hit_next = 1'b0;
        last_next = 1'b0;
        out_word_next = 1'b0;
        tag_we = 1'b0;
        tag_waddr = chosen_reg;
        dat_we = 1'b0;
        dat_waddr = '0;
        dat_wdata = data_reg;
        dat_raddr = '0;
        cl = cmp_reg[LW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next = op_t'(opcode);
                    key_next = in_key;
                    data_next = data_word;
                    if (opcode == OP_PUT && word_index != '0)
                    begin
                        // fill word into the chosen line
                        dat_we = 1'b1;
                        dat_waddr = {chosen_reg, word_index};
                        dat_wdata = data_word;
                    end
                    else
                    begin
                        idx_next = NW'(1);
                        cmp_next = '0;
                        found_next = 1'b0;
                        empty_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // compare the line whose tag came back this cycle
                if (!found_reg && valid_reg[cl] && key_rd == key_reg)
                begin
                    found_next = 1'b1;
                    match_next = cl;
                end
                if (!empty_reg && !valid_reg[cl])
                begin
                    empty_next = 1'b1;
                    empty_idx_next = cl;
                end
                if (cmp_reg == '0 || stamp_rd < best_reg)
                begin
                    best_next = stamp_rd;
                    best_idx_next = cl;
                end
                cmp_next = cmp_reg + NW'(1);
                idx_next = idx_reg + NW'(1);
                if (cmp_reg + NW'(1) >= n_act)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END:
            begin
                if (op_reg == OP_GET)
                begin
                    looks_next = (looks_reg == '1) ? looks_reg : looks_reg + 1'b1;
                    if (found_reg)
                    begin
                        hits_next = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                        w_next = '0;
                        dat_raddr = {match_reg, WIDX_W'(0)};
                        rv_next = 1'b1;
                        hit_next = 1'b1;
                        out_word_next = 1'b1;
                        w_next = WIDX_W'(1);
                        state_next = ST_STREAM;
                    end
                    else
                    begin
                        rv_next = 1'b1;
                        last_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    if (found_reg)
                        chosen_next = match_reg;
                    else if (empty_reg)
                        chosen_next = empty_idx_reg;
                    else
                        chosen_next = best_idx_reg;
                    state_next = ST_PUT_WRITE;
                end
            end
            ST_STREAM:
            begin
                dat_raddr = {match_reg, w_reg};
                rv_next = 1'b1;
                hit_next = 1'b1;
                out_word_next = 1'b1;
                last_next = (w_reg == WIDX_W'(WORDS_PER_LINE - 1));
                w_next = w_reg + 1'b1;
                if (w_reg == WIDX_W'(WORDS_PER_LINE - 1))
                    state_next = ST_IDLE;
            end
            ST_PUT_WRITE:
            begin
                // claim line: key, stamp, valid and word 0
                clock_next = clock_reg + 1'b1;
                tag_we = 1'b1;
                tag_waddr = chosen_reg;
                valid_next[chosen_reg] = 1'b1;
                dat_we = 1'b1;
                dat_waddr = {chosen_reg, WIDX_W'(0)};
                rv_next = 1'b1;
                hit_next = found_reg;
                last_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks on the block's own logic
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_valid) else $error("last without result");
    a_busy_res: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy) else $error("stream ended early");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        hit_count <= access_count) else $error("hits exceed lookups");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the block cache: table-driven directed items, random traffic
`default_nettype none
module tb_top;
    import abc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINES = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_N = 24;

    typedef struct {
        logic        hit;
        logic [63:0] word;
        logic        last;
        logic [31:0] hits;
        logic [31:0] looks;
    } cache_result_t;

    typedef struct {
        op_t         op;
        logic [7:0]  dev;
        logic [15:0] sec;
        logic [15:0] blk;
        logic [4:0]  widx;
        logic [63:0] data;
        bit          typed;
        logic        hit;
        logic [31:0] hits;
        logic [31:0] looks;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = 1'b0;
    logic [7:0]  dev_num = '0;
    logic [15:0] sector = '0;
    logic [15:0] block_num = '0;
    logic [4:0]  word_index = '0;
    logic [63:0] data_word = '0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        result_valid;
    logic        hit;
    logic [63:0] read_word;
    logic        last;
    logic [31:0] hit_count;
    logic [31:0] access_count;

    assoc_block_cache_lru_core #(.LINES(NLINES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .dev_num(dev_num), .sector(sector),
        .block_num(block_num), .word_index(word_index), .data_word(data_word),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .hit(hit), .read_word(read_word),
        .last(last), .hit_count(hit_count), .access_count(access_count)
    );

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the cache
    bit          sh_valid [NLINES];
    logic [39:0] sh_key [NLINES];
    logic [31:0] sh_stamp [NLINES];
    logic [63:0] sh_words [NLINES][32];
    bit   [31:0] sh_written [NLINES];
    logic [31:0] sh_clock;
    int          sh_chosen;
    logic [31:0] sh_hits;
    logic [31:0] sh_looks;
    logic [6:0]  sh_lines;

    cache_result_t pending_results[$];
    int  fail_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  cycles = 0;
    bit  idling_on = 1'b1;
    logic [39:0] key_pool [POOL_N];

    function automatic int active_lines();
        if (sh_lines == 0) return 1;
        if (sh_lines > NLINES) return NLINES;
        return int'(sh_lines);
    endfunction

    function automatic int lookup_line(logic [39:0] k);
        for (int i = 0; i < active_lines(); i++)
            if (sh_valid[i] && sh_key[i] == k) return i;
        return -1;
    endfunction

    // a get hit must never land on a line with unwritten words
    function automatic bit get_is_safe(logic [39:0] k);
        int m;
        m = lookup_line(k);
        return (m < 0) || (sh_written[m] == 32'hFFFF_FFFF);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [39:0] random_key();
        return {8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535))};
    endfunction

    // work out the results of one accepted item and update the shadow cache
    task automatic predict_cache(op_t op, logic [39:0] k, logic [4:0] widx,
                                 logic [63:0] data);
        cache_result_t r;
        int m;
        int sel;
        bit found;
        m = lookup_line(k);
        sel = 0;
        found = 1'b0;
        if (op == OP_GET)
        begin
            sh_looks = sat_inc(sh_looks);
            if (m < 0)
            begin
                r = '{1'b0, 64'd0, 1'b1, sh_hits, sh_looks};
                pending_results.push_back(r);
            end
            else
            begin
                sh_hits = sat_inc(sh_hits);
                for (int w = 0; w < 32; w++)
                begin
                    r = '{1'b1, sh_words[m][w], (w == 31), sh_hits, sh_looks};
                    pending_results.push_back(r);
                end
            end
        end
        else if (widx != 0)
        begin
            sh_words[sh_chosen][widx] = data;
            sh_written[sh_chosen][widx] = 1'b1;
        end
        else
        begin
            if (m >= 0)
                sel = m;
            else
            begin
                for (int i = 0; i < active_lines() && !found; i++)
                    if (!sh_valid[i])
                    begin
                        sel = i;
                        found = 1'b1;
                    end
                // victim: smallest stamp, lowest index on ties
                if (!found)
                    for (int i = 1; i < active_lines(); i++)
                        if (sh_stamp[i] < sh_stamp[sel]) sel = i;
                sh_valid[sel] = 1'b1;
                sh_key[sel] = k;
            end
            sh_clock = sh_clock + 32'd1;
            sh_stamp[sel] = sh_clock;
            sh_chosen = sel;
            sh_words[sel][0] = data;
            sh_written[sel][0] = 1'b1;
            r = '{(m >= 0), 64'd0, 1'b1, sh_hits, sh_looks};
            pending_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // result monitor, receiver never stalls
    always @(posedge clk)
    begin
        cache_result_t e;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, read_word", read_word, 64'd0);
            else
            begin
                e = pending_results.pop_front();
                if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
                if (read_word !== e.word) report_mismatch("read_word", read_word, e.word);
                if (last !== e.last) report_mismatch("last", last, e.last);
                if (hit_count !== e.hits) report_mismatch("hit_count", hit_count, e.hits);
                if (access_count !== e.looks)
                    report_mismatch("access_count", access_count, e.looks);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(op_t op, logic [39:0] k, logic [4:0] widx, logic [63:0] data);
        start <= 1'b1;
        opcode <= op;
        dev_num <= k[39:32];
        sector <= k[31:16];
        block_num <= k[15:0];
        word_index <= widx;
        data_word <= data;
        do @(posedge clk); while (busy);
        predict_cache(op, k, widx, data);
        items_sent++;
    endtask

    task automatic maybe_gap();
        int n;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // quiet period then write the line count
    task automatic write_lines(logic [6:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (NLINES + 40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_lines = v;
    endtask

    // a line: select with word 0 then fill words 1 to fill_words
    task automatic put_line(logic [39:0] k, int fill_words);
        send_item(OP_PUT, k, 5'd0, {$urandom, $urandom});
        maybe_gap();
        for (int w = 1; w <= fill_words; w++)
        begin
            send_item(OP_PUT, k, w[4:0], {$urandom, $urandom});
            maybe_gap();
        end
    endtask

    task automatic random_phase(int n_items);
        int stop_at;
        int pick;
        logic [39:0] k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            k = key_pool[$urandom_range(0, POOL_N - 1)];
            if (pick < 3)
                put_line(k, 31);
            else if (pick < 8)
            begin
                if (get_is_safe(k)) send_item(OP_GET, k, 5'd0, {$urandom, $urandom});
            end
            else if (pick == 8)
            begin
                // noise: stray key lookup or stray fill word
                k = random_key();
                if ($urandom_range(0, 1) && get_is_safe(k))
                    send_item(OP_GET, k, 5'd0, {$urandom, $urandom});
                else if (sh_written[sh_chosen] == 32'hFFFF_FFFF)
                    send_item(OP_PUT, k, 5'($urandom_range(1, 31)), {$urandom, $urandom});
            end
            else
                // broken sequence: select then a partial fill
                put_line(k, $urandom_range(0, 30));
            maybe_gap();
        end
    endtask

    dir_row_t dir_rows[$];

    initial
    begin
        logic [39:0] kmax;
        kmax = 40'hFF_FFFF_FFFF;
        for (int i = 0; i < NLINES; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_written[i] = '0;
            sh_stamp[i] = '0;
            sh_key[i] = '0;
        end
        sh_clock = '0;
        sh_chosen = 0;
        sh_hits = '0;
        sh_looks = '0;
        sh_lines = 7'd64;
        key_pool[0] = '0;
        key_pool[1] = kmax;
        for (int i = 2; i < POOL_N; i++)
            key_pool[i] = random_key();

        // directed table
        dir_rows = '{
            '{OP_GET, 8'h00, 16'h0000, 16'h0000, 5'd0, 64'd0, 1, 1'b0, 0, 1},
            '{OP_GET, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd0, '1, 1, 1'b0, 0, 2},
            '{OP_PUT, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd0, '1, 1, 1'b0, 0, 2},
            '{OP_PUT, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd31, '1, 0, 1'b0, 0, 0},
            '{OP_PUT, 8'h00, 16'h0000, 16'h0000, 5'd1, 64'd0, 0, 1'b0, 0, 0},
            '{OP_PUT, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd0, 64'h0123_4567_89AB_CDEF, 1, 1'b1, 0, 2},
            '{OP_PUT, 8'h00, 16'h0000, 16'h0000, 5'd0, 64'd0, 1, 1'b0, 0, 2},
            '{OP_PUT, 8'h00, 16'h0000, 16'h0000, 5'd16, 64'h8000_0000_0000_0001, 0, 1'b0, 0, 0},
            '{OP_PUT, 8'h80, 16'h8000, 16'h0001, 5'd0, 64'hA5A5_5A5A_A5A5_5A5A, 1, 1'b0, 0, 2},
            '{OP_GET, 8'h80, 16'h8000, 16'h0002, 5'd0, 64'd0, 1, 1'b0, 0, 3},
            '{OP_PUT, 8'h80, 16'h8000, 16'h0001, 5'd0, 64'd0, 1, 1'b1, 0, 3}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset line count
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].op, {dir_rows[i].dev, dir_rows[i].sec, dir_rows[i].blk},
                      dir_rows[i].widx, dir_rows[i].data);
            if (dir_rows[i].typed)
            begin
                pending_results[$].hit = dir_rows[i].hit;
                pending_results[$].hits = dir_rows[i].hits;
                pending_results[$].looks = dir_rows[i].looks;
            end
            maybe_gap();
        end
        // complete the partial lines so gets may hit them later
        put_line(kmax, 31);
        put_line('0, 31);
        send_item(OP_GET, kmax, 5'd0, 64'd0);
        send_item(OP_GET, '0, 5'd0, 64'd0);

        // random traffic over several line counts, extremes included
        random_phase(60);
        write_lines(7'd3);
        random_phase(50);
        write_lines(7'd0);
        random_phase(30);
        write_lines(7'd127);
        random_phase(50);
        write_lines(7'd1);
        random_phase(30);
        write_lines(7'($urandom_range(2, 63)));
        random_phase(35);
        write_lines(7'd64);
        idling_on = 1'b0;
        random_phase(35);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (NLINES + 40) @(posedge clk);
        $display("covered %0d items and %0d results over line counts 64, 3, 0, 127, 1, random",
                 items_sent, results_seen);
        $display("mismatches: %0d", fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/abc_pkg.sv
hdl/abc_ram.sv
hdl/assoc_block_cache_lru_core.sv
tb/tb_top.sv
